/* rtl/pfpe_pkg.sv */
package pfpe_pkg;

  localparam int SCREEN_WIDTH = 128;
  localparam int SCREEN_PAGES = 8;

  localparam int SCREEN_ROWS = SCREEN_PAGES * 8;
  localparam int STORE_BYTES = SCREEN_WIDTH * SCREEN_PAGES;

  localparam int COL_W  = $clog2(SCREEN_WIDTH);
  localparam int PAGE_W = (SCREEN_PAGES > 1) ? $clog2(SCREEN_PAGES) : 1;
  localparam int ROW_W  = $clog2(SCREEN_ROWS);
  localparam int ADDR_W = $clog2(STORE_BYTES);
  localparam int CMP_W  = 10;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] CMD_POINT = 2'd0;
  localparam logic [1:0] CMD_FILL  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam logic [1:0] JOB_SKIP  = 2'd0;
  localparam logic [1:0] JOB_FILL  = 2'd1;
  localparam logic [1:0] JOB_CLEAR = 2'd2;
  localparam logic [1:0] JOB_READ  = 2'd3;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] x_start;
    logic [7:0] y_start;
    logic [7:0] x_end;
    logic [7:0] y_end;
    logic       dot;
    logic [2:0] page_index;
  } pfpe_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       in_range;
  } pfpe_out_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [COL_W-1:0]  col_lo;
    logic [COL_W-1:0]  col_hi;
    logic [PAGE_W-1:0] page_lo;
    logic [PAGE_W-1:0] page_hi;
    logic [ROW_W-1:0]  row_lo;
    logic [ROW_W-1:0]  row_hi;
    logic              dot;
    logic              hit;
  } pfpe_job_t;

  function automatic logic [ADDR_W-1:0] byte_addr(input logic [COL_W-1:0] col,
                                                  input logic [PAGE_W-1:0] page);
    logic [ADDR_W+1:0] a;
    a = (ADDR_W+2)'(col) * (ADDR_W+2)'(SCREEN_PAGES) + (ADDR_W+2)'(page);
    return a[ADDR_W-1:0];
  endfunction

  function automatic logic [7:0] page_mask(input logic [PAGE_W-1:0] page,
                                           input logic [ROW_W-1:0]  row_lo,
                                           input logic [ROW_W-1:0]  row_hi);
    logic [7:0]       m;
    logic [CMP_W-1:0] r;
    m = 8'h00;
    for (int n = 0; n < 8; n++) begin
      r = (CMP_W'(page) << 3) + CMP_W'(n);
      m[n] = (r >= CMP_W'(row_lo)) && (r <= CMP_W'(row_hi));
    end
    return m;
  endfunction

endpackage

/* rtl/page_framebuffer_pixel_engine.sv */
// Monochrome frame store of 128 columns by 8 pages, each byte holding eight vertically
// stacked pixels of one column. After reset the store is swept to zero, one byte a cycle,
// and in_stall stays high throughout. Commands pass through a two-beat queue to an engine
// that works on the store one byte at a time through a single read-modify-write path. An
// on-screen point or read passes from idle through a modify or read-data state, and an
// off-screen one finishes in idle; a fill writes every byte it touches (columns times pages
// spanned) in turn; a clear sweeps the whole store to zero. Every command gives exactly one
// result beat, held in an output register, so the queue keeps accepting while a result
// waits; the engine itself waits only when a new result is ready while the previous beat
// is still held.
module page_framebuffer_pixel_engine
  import pfpe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  pfpe_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output pfpe_out_t out_data
);

  logic      q_full;
  logic      q_push;
  pfpe_job_t q_job;
  logic      q_pop;
  logic      head_valid;
  pfpe_job_t head_job;
  logic      init_busy;

  pfpe_front u_front (
    .in_valid  (in_valid),
    .in_data   (in_data),
    .q_full    (q_full),
    .init_busy (init_busy),
    .in_stall  (in_stall),
    .q_push    (q_push),
    .q_job     (q_job)
  );

  pfpe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  pfpe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (q_pop),
    .init_busy  (init_busy),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

/* rtl/pfpe_front.sv */
module pfpe_front
  import pfpe_pkg::*;
(
  input  logic      in_valid,
  input  pfpe_in_t  in_data,
  input  logic      q_full,
  input  logic      init_busy,
  output logic      in_stall,
  output logic      q_push,
  output pfpe_job_t q_job
);

  logic             x_on;
  logic             y_on;
  logic             pg_on;
  logic [CMP_W-1:0] x2c;
  logic [CMP_W-1:0] y2c;

  assign in_stall = q_full || init_busy;
  assign q_push   = in_valid && !in_stall;

  always_comb begin
    x_on  = CMP_W'(in_data.x_start) < CMP_W'(SCREEN_WIDTH);
    y_on  = CMP_W'(in_data.y_start) < CMP_W'(SCREEN_ROWS);
    pg_on = CMP_W'(in_data.page_index) < CMP_W'(SCREEN_PAGES);
    x2c   = (CMP_W'(in_data.x_end) > CMP_W'(SCREEN_WIDTH - 1)) ?
            CMP_W'(SCREEN_WIDTH - 1) : CMP_W'(in_data.x_end);
    y2c   = (CMP_W'(in_data.y_end) > CMP_W'(SCREEN_ROWS - 1)) ?
            CMP_W'(SCREEN_ROWS - 1) : CMP_W'(in_data.y_end);

    q_job     = '0;
    q_job.op  = JOB_SKIP;
    q_job.dot = in_data.dot;

    unique case (in_data.cmd)
      CMD_POINT: begin
        if (x_on && y_on) begin
          q_job.op      = JOB_FILL;
          q_job.col_lo  = COL_W'(in_data.x_start);
          q_job.col_hi  = COL_W'(in_data.x_start);
          q_job.row_lo  = ROW_W'(in_data.y_start);
          q_job.row_hi  = ROW_W'(in_data.y_start);
          q_job.page_lo = PAGE_W'(in_data.y_start >> 3);
          q_job.page_hi = PAGE_W'(in_data.y_start >> 3);
          q_job.hit     = 1'b1;
        end
      end
      CMD_FILL: begin
        if ((CMP_W'(in_data.x_start) <= x2c) && (CMP_W'(in_data.y_start) <= y2c)) begin
          q_job.op      = JOB_FILL;
          q_job.col_lo  = COL_W'(in_data.x_start);
          q_job.col_hi  = COL_W'(x2c);
          q_job.row_lo  = ROW_W'(in_data.y_start);
          q_job.row_hi  = ROW_W'(y2c);
          q_job.page_lo = PAGE_W'(in_data.y_start >> 3);
          q_job.page_hi = PAGE_W'(y2c >> 3);
        end
      end
      CMD_CLEAR: begin
        q_job.op = JOB_CLEAR;
      end
      CMD_READ: begin
        if (x_on && pg_on) begin
          q_job.op      = JOB_READ;
          q_job.col_lo  = COL_W'(in_data.x_start);
          q_job.page_lo = PAGE_W'(in_data.page_index);
          q_job.hit     = 1'b1;
        end
      end
      default: begin
        q_job.op = JOB_SKIP;
      end
    endcase
  end

endmodule

/* rtl/pfpe_queue.sv */
module pfpe_queue
  import pfpe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  pfpe_job_t push_job,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output pfpe_job_t head_job
);

  pfpe_job_t         slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;

  assign full       = count_r == QCNT_W'(QUEUE_DEPTH);
  assign head_valid = count_r != '0;
  assign head_job   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

/* rtl/pfpe_back.sv */
module pfpe_back
  import pfpe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  pfpe_job_t head_job,
  output logic      pop,
  output logic      init_busy,
  output logic      out_valid,
  input  logic      out_stall,
  output pfpe_out_t out_data
);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_RDATA = 3'd3;
  localparam logic [2:0] S_CLR   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [7:0] mem [STORE_BYTES];

  logic [2:0]        state_r;
  logic [2:0]        state_nxt;
  pfpe_job_t         job_r;
  pfpe_job_t         job_nxt;
  logic [COL_W-1:0]  col_r;
  logic [COL_W-1:0]  col_nxt;
  logic [PAGE_W-1:0] page_r;
  logic [PAGE_W-1:0] page_nxt;
  logic [ADDR_W-1:0] clr_addr_r;
  logic [ADDR_W-1:0] clr_addr_nxt;
  pfpe_out_t         res_r;
  pfpe_out_t         res_nxt;
  pfpe_out_t         out_r;
  pfpe_out_t         out_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;

  logic [7:0]        rdata_r;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]        wdata;
  logic              we;
  logic              finish;
  pfpe_out_t         res;
  logic              out_free;
  logic              last_pg;
  logic              last_clr;
  logic [7:0]        mask;

  assign init_busy = state_r == S_INIT;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign last_pg   = page_r == job_r.page_hi;
  assign last_clr  = clr_addr_r == ADDR_W'(STORE_BYTES - 1);
  assign mask      = page_mask(page_r, job_r.row_lo, job_r.row_hi);

  always_comb begin
    state_nxt    = state_r;
    job_nxt      = job_r;
    col_nxt      = col_r;
    page_nxt     = page_r;
    clr_addr_nxt = clr_addr_r;
    res_nxt      = res_r;
    pop          = 1'b0;
    we           = 1'b0;
    waddr        = byte_addr(col_r, page_r);
    wdata        = job_r.dot ? (rdata_r | mask) : (rdata_r & ~mask);
    raddr        = byte_addr(head_job.col_lo, head_job.page_lo);
    finish       = 1'b0;
    res          = '0;

    unique case (state_r)
      S_INIT: begin
        we    = 1'b1;
        waddr = clr_addr_r;
        wdata = 8'h00;
        if (last_clr) begin
          clr_addr_nxt = '0;
          state_nxt    = S_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        end
      end
      S_IDLE: begin
        if (head_valid) begin
          pop      = 1'b1;
          job_nxt  = head_job;
          col_nxt  = head_job.col_lo;
          page_nxt = head_job.page_lo;
          unique case (head_job.op)
            JOB_FILL:  state_nxt = S_MOD;
            JOB_READ:  state_nxt = S_RDATA;
            JOB_CLEAR: state_nxt = S_CLR;
            default: begin
              finish = 1'b1;
              res    = '0;
            end
          endcase
        end
      end
      S_MOD: begin
        we = 1'b1;
        if (last_pg) begin
          page_nxt = job_r.page_lo;
          col_nxt  = col_r + COL_W'(1);
        end else begin
          page_nxt = page_r + PAGE_W'(1);
        end
        raddr = byte_addr(col_nxt, page_nxt);
        if (last_pg && (col_r == job_r.col_hi)) begin
          finish       = 1'b1;
          res.in_range = job_r.hit;
        end
      end
      S_RDATA: begin
        finish         = 1'b1;
        res.read_data  = rdata_r;
        res.in_range   = job_r.hit;
      end
      S_CLR: begin
        we    = 1'b1;
        waddr = clr_addr_r;
        wdata = 8'h00;
        if (last_clr) begin
          clr_addr_nxt = '0;
          finish       = 1'b1;
        end else begin
          clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (finish) begin
      res_nxt   = res;
      state_nxt = out_free ? S_IDLE : S_DONE;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    if (finish && out_free) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end else if ((state_r == S_DONE) && out_free) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    col_r  <= col_nxt;
    page_r <= page_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

/* test/pixel_result_checker.sv */
`timescale 1ns / 100ps

module pixel_result_checker
  import pfpe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  pfpe_in_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  pfpe_out_t out_data,
  output int        fail_count,
  output int        results_owed
);

  logic [7:0] frame_bytes [STORE_BYTES];
  pfpe_out_t  expected_results [$];

  initial begin
    fail_count   = 0;
    results_owed = 0;
  end

  function automatic bit plot_pixel(input int col, input int row, input logic dot);
    int a;
    if (col >= SCREEN_WIDTH || row >= SCREEN_ROWS) return 1'b0;
    a = col * SCREEN_PAGES + (row >> 3);
    frame_bytes[a][row & 7] = dot;
    return 1'b1;
  endfunction

  // Applies one command beat to the mirrored store and returns the result it must give.
  function automatic pfpe_out_t apply_command(input pfpe_in_t c);
    pfpe_out_t r;
    int        x_hi;
    int        y_hi;
    bit        on_screen;
    r = '0;
    case (c.cmd)
      CMD_POINT: begin
        r.in_range = plot_pixel(int'(c.x_start), int'(c.y_start), c.dot);
      end
      CMD_FILL: begin
        if (c.x_start <= c.x_end && c.y_start <= c.y_end) begin
          x_hi = (int'(c.x_end) > SCREEN_WIDTH - 1) ? SCREEN_WIDTH - 1 : int'(c.x_end);
          y_hi = (int'(c.y_end) > SCREEN_ROWS - 1) ? SCREEN_ROWS - 1 : int'(c.y_end);
          for (int x = int'(c.x_start); x <= x_hi; x++) begin
            for (int y = int'(c.y_start); y <= y_hi; y++) begin
              on_screen = plot_pixel(x, y, c.dot);
            end
          end
        end
      end
      CMD_CLEAR: begin
        foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
      end
      default: begin
        if (int'(c.x_start) < SCREEN_WIDTH && int'(c.page_index) < SCREEN_PAGES) begin
          r.read_data = frame_bytes[int'(c.x_start) * SCREEN_PAGES + int'(c.page_index)];
          r.in_range  = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    pfpe_out_t want;
    if (!rst_n) begin
      foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
      expected_results.delete();
    end else begin
      if (in_valid && !in_stall) expected_results.push_back(apply_command(in_data));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result beat arrived with no command outstanding");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.read_data !== want.read_data) begin
            $error("read_data: expected %0h, got %0h", want.read_data, out_data.read_data);
            fail_count++;
          end
          if (out_data.in_range !== want.in_range) begin
            $error("in_range: expected %0b, got %0b", want.in_range, out_data.in_range);
            fail_count++;
          end
        end
      end
    end
    results_owed = expected_results.size();
  end

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import pfpe_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  pfpe_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  pfpe_out_t out_data;
  int        fail_count;
  int        results_owed;
  bit        steady;

  page_framebuffer_pixel_engine i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  pixel_result_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  initial begin
    clk       = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    steady    = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 14);
  end

  function automatic pfpe_in_t make_cmd(input logic [1:0] cmd, input int xs, input int ys,
                                        input int xe, input int ye, input logic dot,
                                        input int page);
    pfpe_in_t c;
    c.cmd        = cmd;
    c.x_start    = 8'(xs);
    c.y_start    = 8'(ys);
    c.x_end      = 8'(xe);
    c.y_end      = 8'(ye);
    c.dot        = dot;
    c.page_index = 3'(page);
    return c;
  endfunction

  function automatic pfpe_in_t random_cmd();
    pfpe_in_t c;
    int       pick;
    pick = $urandom_range(99);
    c = make_cmd(CMD_POINT, $urandom_range(255), $urandom_range(255), $urandom_range(255),
                 $urandom_range(255), 1'($urandom_range(1)), $urandom_range(7));
    if (pick < 36) begin
      if ($urandom_range(9) != 0) begin
        c.x_start = 8'($urandom_range(127));
        c.y_start = 8'($urandom_range(63));
      end
    end else if (pick < 70) begin
      c.cmd = CMD_READ;
      if ($urandom_range(9) != 0) c.x_start = 8'($urandom_range(127));
    end else if (pick < 97) begin
      c.cmd = CMD_FILL;
      if ($urandom_range(4) != 0) begin
        c.x_start = 8'($urandom_range(135));
        c.x_end   = 8'(int'(c.x_start) + $urandom_range(12));
        c.y_start = 8'($urandom_range(70));
        c.y_end   = 8'(int'(c.y_start) + $urandom_range(20));
      end
    end else begin
      c.cmd = CMD_CLEAR;
    end
    return c;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_cmd(input pfpe_in_t c);
    while (!steady && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (results_owed != 0) @(negedge clk);
  endtask

  initial begin
    pfpe_in_t directed [$];
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    directed.push_back(make_cmd(CMD_READ,  0,   0,   0,   0,   1'b0, 0));
    directed.push_back(make_cmd(CMD_POINT, 0,   0,   255, 255, 1'b1, 7));
    directed.push_back(make_cmd(CMD_POINT, 127, 63,  0,   0,   1'b1, 0));
    directed.push_back(make_cmd(CMD_POINT, 128, 0,   0,   0,   1'b1, 0));
    directed.push_back(make_cmd(CMD_POINT, 0,   64,  0,   0,   1'b1, 0));
    directed.push_back(make_cmd(CMD_POINT, 255, 255, 0,   0,   1'b1, 0));
    directed.push_back(make_cmd(CMD_READ,  0,   0,   0,   0,   1'b0, 0));
    directed.push_back(make_cmd(CMD_READ,  127, 0,   0,   0,   1'b0, 7));
    directed.push_back(make_cmd(CMD_READ,  128, 0,   0,   0,   1'b0, 0));
    directed.push_back(make_cmd(CMD_READ,  255, 255, 255, 255, 1'b1, 7));
    directed.push_back(make_cmd(CMD_FILL,  0,   0,   255, 255, 1'b1, 0));
    directed.push_back(make_cmd(CMD_READ,  64,  0,   0,   0,   1'b0, 3));
    directed.push_back(make_cmd(CMD_FILL,  10,  5,   9,   20,  1'b0, 0));
    directed.push_back(make_cmd(CMD_FILL,  5,   20,  10,  19,  1'b0, 0));
    directed.push_back(make_cmd(CMD_FILL,  120, 60,  200, 100, 1'b0, 0));
    directed.push_back(make_cmd(CMD_READ,  120, 0,   0,   0,   1'b0, 7));
    directed.push_back(make_cmd(CMD_READ,  119, 0,   0,   0,   1'b0, 7));
    directed.push_back(make_cmd(CMD_POINT, 3,   9,   0,   0,   1'b0, 0));
    directed.push_back(make_cmd(CMD_READ,  3,   0,   0,   0,   1'b0, 1));
    directed.push_back(make_cmd(CMD_FILL,  200, 70,  255, 255, 1'b1, 0));
    directed.push_back(make_cmd(CMD_CLEAR, 0,   0,   0,   0,   1'b0, 0));
    directed.push_back(make_cmd(CMD_READ,  64,  0,   0,   0,   1'b0, 3));
    directed.push_back(make_cmd(CMD_FILL,  2,   3,   5,   13,  1'b1, 0));
    directed.push_back(make_cmd(CMD_READ,  4,   0,   0,   0,   1'b0, 0));
    directed.push_back(make_cmd(CMD_READ,  4,   0,   0,   0,   1'b0, 1));
    foreach (directed[i]) send_cmd(directed[i]);

    for (int n = 0; n < 1100; n++) begin
      steady = (n >= 300 && n < 500);
      if (n == 200 || n == 700) drain_results();
      send_cmd(random_cmd());
    end
    steady = 1'b0;

    in_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (1100) @(negedge clk);
    if (fail_count == 0 && results_owed == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #50000000;
    $display("tb: failure");
    $finish;
  end

endmodule

/* sim.f */
rtl/pfpe_pkg.sv
rtl/pfpe_front.sv
rtl/pfpe_queue.sv
rtl/pfpe_back.sv
rtl/page_framebuffer_pixel_engine.sv
test/pixel_result_checker.sv
test/testbench.sv
